[rtl/rmvc_pkg.sv]
// Package for the running mean and variance block: constants, state types and link structs.
package rmvc_pkg;

  localparam int SAMPLE_W   = 32;
  localparam int COUNT_W    = 32;
  localparam int MEAN_W     = 48;
  localparam int VAR_W      = 64;
  localparam int VAR_FRAC   = 8;
  localparam int CUTOFF_W   = 32;

  localparam int DEF_COUNT_BITS  = 32;
  localparam int DEF_SAMPLE_BITS = 32;
  localparam int DEF_FRAC_BITS   = 16;

  localparam logic [CUTOFF_W-1:0] CUTOFF_RESET = 32'd1000000;

  typedef enum logic [2:0] {
    U_IDLE,
    U_DONE,
    U_DIV1,
    U_MEAN,
    U_MUL,
    U_ADD,
    U_DIV2,
    U_FIN
  } unit_state_t;

  typedef enum logic {
    T_IDLE,
    T_RUN
  } top_state_t;

  typedef struct packed {
    logic                start;
    logic                en;
    logic [SAMPLE_W-1:0] x;
  } set_cmd_t;

  typedef struct packed {
    logic               idle;
    logic [COUNT_W-1:0] count;
    logic [MEAN_W-1:0]  mean;
    logic [VAR_W-1:0]   var_q;
  } set_stat_t;

endpackage

[rtl/rmvc_in_if.sv]
// Input channel interface: valid, ready and the sample.
interface rmvc_in_if import rmvc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink (input valid, input sample, output ready);
endinterface

[rtl/rmvc_out_if.sv]
// Result channel interface: valid, ready and both statistics sets.
interface rmvc_out_if import rmvc_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] total_count;
  logic [MEAN_W-1:0]  mean_all;
  logic [VAR_W-1:0]   variance_all;
  logic               is_inlier;
  logic [COUNT_W-1:0] inlier_count;
  logic [MEAN_W-1:0]  mean_inliers;
  logic [VAR_W-1:0]   variance_inliers;

  modport source (output valid, output total_count, output mean_all, output variance_all,
                  output is_inlier, output inlier_count, output mean_inliers,
                  output variance_inliers, input ready);
  modport sink (input valid, input total_count, input mean_all, input variance_all,
                input is_inlier, input inlier_count, input mean_inliers,
                input variance_inliers, output ready);
endinterface

[rtl/running_mean_variance_with_cutoff_top.sv]
// Top level: running mean and variance over all samples and over inliers below a cutoff.
//
//  channel   dir  handshake        payload
//  in_ch     in   valid / ready    sample
//  out_ch    out  valid / ready    total_count .. variance_inliers
//  cfg       in   cfg_we           cfg_data (outlier_cutoff)
//
// A set unit works a sample in steps: 48 divider steps for the mean, one mean update,
// 48 shift-add multiplier steps, one add, 64 divider steps for the variance and one
// final step; the first sample of a set, or a sample the set skips, goes straight to U_DONE.
// Both sets run side by side in their own bit-serial units. The result register loads
// once both units are idle and the output register is free, and the input is ready
// again in the cycle after.
// A sample is taken only when no sample is in flight; a finished result waits in the
// output register, and a new sample may run while it waits; that sample then holds
// until the waiting transaction leaves, and the input stalls meanwhile.
// Reset (rst, synchronous) clears all counts, means and variances and sets the cutoff
// to 1000000.
module running_mean_variance_with_cutoff_top import rmvc_pkg::*; #(
  parameter int COUNT_BITS  = DEF_COUNT_BITS,
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  logic                clk,
  input  logic                rst,
  rmvc_in_if.sink             in_ch,
  rmvc_out_if.source          out_ch,
  input  logic                cfg_we,
  input  logic [CUTOFF_W-1:0] cfg_data
);

  top_state_t state, state_next;
  logic [CUTOFF_W-1:0] cutoff;
  logic                inlier;
  logic [SAMPLE_W-1:0] x;
  logic                accept;
  logic                finish;
  set_cmd_t            cmd_all, cmd_in;
  set_stat_t           stat_all, stat_in;

  assign x      = SAMPLE_W'(in_ch.sample[SAMPLE_BITS-1:0]);
  assign accept = in_ch.valid && in_ch.ready;
  assign finish = (state == T_RUN) && stat_all.idle && stat_in.idle
                  && (!out_ch.valid || out_ch.ready);

  always_comb begin
    cmd_all.start = accept;
    cmd_all.en    = 1'b1;
    cmd_all.x     = x;
    cmd_in.start  = accept;
    cmd_in.en     = x < cutoff;
    cmd_in.x      = x;
  end

  rmvc_set_unit #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_all (
    .clk(clk), .rst(rst), .cmd(cmd_all), .stat(stat_all)
  );

  rmvc_set_unit #(.COUNT_BITS(COUNT_BITS), .FRAC_BITS(FRAC_BITS)) u_in (
    .clk(clk), .rst(rst), .cmd(cmd_in), .stat(stat_in)
  );

  always_comb begin
    state_next = state;
    case (state)
      T_IDLE:  if (accept) state_next = T_RUN;
      T_RUN:   if (finish) state_next = T_IDLE;
      default: state_next = T_IDLE;
    endcase
  end

  always_comb begin
    in_ch.ready = (state == T_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= T_IDLE;
      cutoff       <= CUTOFF_RESET;
      out_ch.valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) cutoff <= cfg_data;
      if (finish) begin
        out_ch.valid <= 1'b1;
      end else if (out_ch.ready) begin
        out_ch.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) inlier <= x < cutoff;
    if (finish) begin
      out_ch.total_count      <= stat_all.count;
      out_ch.mean_all         <= stat_all.mean;
      out_ch.variance_all     <= stat_all.var_q;
      out_ch.is_inlier        <= inlier;
      out_ch.inlier_count     <= stat_in.count;
      out_ch.mean_inliers     <= stat_in.mean;
      out_ch.variance_inliers <= stat_in.var_q;
    end
  end

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !in_ch.ready) else $error("sample taken while a sample is in flight");

  a_inliers_bounded: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid |-> out_ch.inlier_count <= out_ch.total_count)
    else $error("inlier count above total count");

  a_units_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> !stat_all.idle && !stat_in.idle) else $error("set unit did not start");
`endif

endmodule

[rtl/rmvc_set_unit.sv]
// One statistics set: count, mean and variance with a bit-serial divider and multipliers.
module rmvc_set_unit import rmvc_pkg::*; #(
  parameter int COUNT_BITS = DEF_COUNT_BITS,
  parameter int FRAC_BITS  = DEF_FRAC_BITS
) (
  input  logic      clk,
  input  logic      rst,
  input  set_cmd_t  cmd,
  output set_stat_t stat
);

  localparam int CW   = COUNT_BITS;
  localparam int MW   = MEAN_W;
  localparam int VW   = VAR_W;
  localparam int DQW  = VW;
  localparam int PW1  = VW + MW;
  localparam int PW2  = 2 * MW;
  localparam int AW   = 2 * VW;
  localparam int SH_R = (2 * FRAC_BITS > VAR_FRAC) ? 2 * FRAC_BITS - VAR_FRAC : 0;
  localparam int SH_L = (2 * FRAC_BITS < VAR_FRAC) ? VAR_FRAC - 2 * FRAC_BITS : 0;
  localparam logic [6:0] LAST_MW = 7'(MW - 1);
  localparam logic [6:0] LAST_VW = 7'(VW - 1);
  localparam logic [CW-1:0] CMAX = '1;

  unit_state_t state, state_next;
  logic [6:0]     cnt;
  logic [CW-1:0]  count;
  logic [MW-1:0]  mean;
  logic [VW-1:0]  var_q;
  logic [CW-1:0]  n;
  logic [MW-1:0]  d1;
  logic           neg;
  logic [CW-1:0]  rem;
  logic [DQW-1:0] dq;
  logic [PW1-1:0] p1;
  logic [PW2-1:0] p2;
  logic           sat;

  logic [MW-1:0]  xf;
  logic [CW-1:0]  n_calc;
  logic [CW:0]    rem_sh;
  logic           ge;
  logic [CW:0]    rem_sub;
  logic [VW:0]    s1;
  logic [MW:0]    s2;
  logic [MW-1:0]  q1;
  logic [MW-1:0]  d2;
  logic [AW-1:0]  acc;

  always_comb begin
    xf      = MW'({{(MW - SAMPLE_W){1'b0}}, cmd.x} << FRAC_BITS);
    n_calc  = (count == CMAX) ? CMAX : count + 1'b1;
    rem_sh  = {rem, dq[DQW-1]};
    ge      = rem_sh >= {1'b0, n};
    rem_sub = rem_sh - {1'b0, n};
    s1      = {1'b0, p1[PW1-1:MW]} + (p1[0] ? {1'b0, var_q} : '0);
    s2      = {1'b0, p2[PW2-1:MW]} + (p2[0] ? {1'b0, d1} : '0);
    q1      = dq[MW-1:0];
    d2      = d1 - q1;
    acc     = {{(AW - PW1){1'b0}}, p1}
            + (({{(AW - PW2){1'b0}}, p2} >> SH_R) << SH_L);
  end

  always_comb begin
    state_next = state;
    case (state)
      U_IDLE: begin
        if (cmd.start) begin
          state_next = (cmd.en && count != '0) ? U_DIV1 : U_DONE;
        end
      end
      U_DONE: state_next = U_IDLE;
      U_DIV1: if (cnt == LAST_MW) state_next = U_MEAN;
      U_MEAN: state_next = U_MUL;
      U_MUL:  if (cnt == LAST_MW) state_next = U_ADD;
      U_ADD:  state_next = U_DIV2;
      U_DIV2: if (cnt == LAST_VW) state_next = U_FIN;
      U_FIN:  state_next = U_IDLE;
      default: state_next = U_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= U_IDLE;
      cnt   <= '0;
      count <= '0;
      mean  <= '0;
      var_q <= '0;
    end else begin
      state <= state_next;
      cnt   <= (state == U_DIV1 || state == U_MUL || state == U_DIV2) ? cnt + 1'b1 : '0;
      case (state)
        U_IDLE: begin
          if (cmd.start && cmd.en) begin
            if (count == '0) begin
              count <= CW'(1);
              mean  <= xf;
              var_q <= '0;
            end else begin
              count <= n_calc;
              n     <= n_calc;
              neg   <= xf < mean;
              d1    <= (xf >= mean) ? xf - mean : mean - xf;
              rem   <= '0;
              dq    <= (xf >= mean) ? {xf - mean, {(DQW - MW){1'b0}}}
                                    : {mean - xf, {(DQW - MW){1'b0}}};
            end
          end
        end
        U_DIV1, U_DIV2: begin
          // restoring division, one quotient bit per cycle
          rem <= ge ? rem_sub[CW-1:0] : rem_sh[CW-1:0];
          dq  <= {dq[DQW-2:0], ge};
        end
        U_MEAN: begin
          mean <= neg ? mean - q1 : mean + q1;
          p1   <= {{VW{1'b0}}, MW'(n - 1'b1)};
          p2   <= {{MW{1'b0}}, d2};
        end
        U_MUL: begin
          p1 <= {s1, p1[MW-1:1]};
          p2 <= {s2, p2[MW-1:1]};
        end
        U_ADD: begin
          sat <= acc[AW-1:VW] >= VW'(n);
          rem <= acc[VW+CW-1:VW];
          dq  <= acc[VW-1:0];
        end
        U_FIN: var_q <= sat ? '1 : dq;
        default: ;
      endcase
    end
  end

  always_comb begin
    stat.idle  = (state == U_IDLE);
    stat.count = COUNT_W'(count);
    stat.mean  = mean;
    stat.var_q = var_q;
  end

endmodule

[verif/running_mean_variance_with_cutoff_top_test.sv]
// Testbench for the running mean and variance block with an outlier cutoff.
`timescale 1ns / 1ps

module running_mean_variance_with_cutoff_top_test import rmvc_pkg::*; ();

  localparam int LIMIT_CYCLES = 2000000;
  localparam int SETTLE_CYCLES = 400;

  typedef struct packed {
    logic [COUNT_W-1:0] total_count;
    logic [MEAN_W-1:0]  mean_all;
    logic [VAR_W-1:0]   variance_all;
    logic               is_inlier;
    logic [COUNT_W-1:0] inlier_count;
    logic [MEAN_W-1:0]  mean_inliers;
    logic [VAR_W-1:0]   variance_inliers;
  } stats_rec_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CUTOFF_W-1:0] cfg_data;

  rmvc_in_if  in_ch ();
  rmvc_out_if out_ch ();

  running_mean_variance_with_cutoff_top DUT (
    .clk      (clk),
    .rst      (rst),
    .in_ch    (in_ch.sink),
    .out_ch   (out_ch.source),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // Shadow statistics: index 0 covers all samples, index 1 the inliers.
  logic [COUNT_W-1:0] run_count [2];
  logic [MEAN_W-1:0]  run_mean [2];
  logic [VAR_W-1:0]   run_var [2];
  logic [CUTOFF_W-1:0] cutoff_shadow;

  logic [SAMPLE_W-1:0] sample_q [$];
  stats_rec_t          stats_q [$];
  int mismatches;
  int cycles;
  int accepted;
  int drv_gap;
  int rcv_gap;
  bit drv_burst;
  bit rcv_burst;
  logic hold_off;

  function void fold_sample(int s, logic [SAMPLE_W-1:0] x);
    logic [MEAN_W-1:0] xf, n, m_new, d1, d2;
    logic [127:0] acc, quo;
    xf = {x, 16'b0};
    if (run_count[s] == 0) begin
      run_count[s] = 1;
      run_mean[s] = xf;
      run_var[s] = 0;
      return;
    end
    if (run_count[s] != '1) run_count[s] = run_count[s] + 1;
    n = MEAN_W'(run_count[s]);
    if (xf >= run_mean[s]) begin
      d1 = xf - run_mean[s];
      m_new = run_mean[s] + d1 / n;
      d2 = xf - m_new;
    end else begin
      d1 = run_mean[s] - xf;
      m_new = run_mean[s] - d1 / n;
      d2 = m_new - xf;
    end
    acc = 128'(run_var[s]) * 128'(n - 1) + ((128'(d1) * 128'(d2)) >> 24);
    quo = acc / 128'(n);
    run_var[s] = (quo[127:64] != 0) ? '1 : quo[63:0];
    run_mean[s] = m_new;
  endfunction

  function stats_rec_t predict_stats(logic [SAMPLE_W-1:0] x);
    stats_rec_t r;
    r.is_inlier = x < cutoff_shadow;
    fold_sample(0, x);
    if (r.is_inlier) fold_sample(1, x);
    r.total_count = run_count[0];
    r.mean_all = run_mean[0];
    r.variance_all = run_var[0];
    r.inlier_count = run_count[1];
    r.mean_inliers = run_mean[1];
    r.variance_inliers = run_var[1];
    return r;
  endfunction

  function int draw_gap(bit burst);
    return burst ? 0 : $urandom_range(0, 4);
  endfunction

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  // Sender: offer pending samples with random gaps.
  always @(posedge clk) begin
    bit offer;
    if (rst) begin
      in_ch.valid <= 0;
      in_ch.sample <= 0;
      drv_gap = 0;
      drv_burst <= 0;
    end else begin
      offer = in_ch.valid;
      if (in_ch.valid && in_ch.ready) begin
        stats_q.push_back(predict_stats(sample_q.pop_front()));
        accepted <= accepted + 1;
        if ($urandom_range(0, 15) == 0) drv_burst <= ~drv_burst;
        drv_gap = draw_gap(drv_burst);
        offer = 0;
      end
      if (!offer) begin
        if (drv_gap > 0) drv_gap = drv_gap - 1;
        else if (sample_q.size() > 0) begin
          offer = 1;
          in_ch.sample <= sample_q[0];
        end
      end
      in_ch.valid <= offer;
    end
  end

  // Receiver: check each transaction against the oldest expectation.
  always @(posedge clk) begin
    stats_rec_t got, want;
    bit rdy;
    if (rst) begin
      out_ch.ready <= 0;
      rcv_gap = 0;
      rcv_burst <= 0;
    end else begin
      rdy = out_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        got = '{out_ch.total_count, out_ch.mean_all, out_ch.variance_all, out_ch.is_inlier,
                out_ch.inlier_count, out_ch.mean_inliers, out_ch.variance_inliers};
        if (stats_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result transaction: %p", got);
        end else begin
          want = stats_q.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch\n  expected %p\n  actual   %p", want, got);
          end
        end
        if ($urandom_range(0, 15) == 0) rcv_burst <= ~rcv_burst;
        rcv_gap = draw_gap(rcv_burst);
        rdy = 0;
      end
      if (!rdy && rcv_gap > 0) rcv_gap = rcv_gap - 1;
      else rdy = 1;
      out_ch.ready <= rdy && !hold_off;
    end
  end

  // Long receiver hold-off while the sender keeps offering.
  initial begin
    hold_off = 0;
    wait (accepted >= 20);
    @(posedge clk);
    hold_off <= 1;
    repeat (1500) @(posedge clk);
    hold_off <= 0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT_CYCLES) begin
      $display("** running_mean_variance_with_cutoff_top: FAILED **");
      $finish;
    end
  end

  task automatic drain();
    wait (sample_q.size() == 0 && stats_q.size() == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_cutoff(logic [CUTOFF_W-1:0] v);
    @(posedge clk);
    cfg_we <= 1;
    cfg_data <= v;
    cutoff_shadow = v;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  task automatic queue_random(int count);
    logic [SAMPLE_W-1:0] x;
    repeat (count) begin
      case ($urandom_range(0, 5))
        0: x = $urandom;
        1: x = $urandom_range(0, 3) == 0 ? '1 : 0;
        2: x = cutoff_shadow + $urandom_range(0, 4) - 2;
        3: x = $urandom_range(0, 2000);
        default: x = $urandom_range(900000, 1100000);
      endcase
      sample_q.push_back(x);
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] directed [] = '{0, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 999999, 1000000,
                                         1000001, 1, 32'hAAAA_AAAA, 32'h5555_5555, 12345,
                                         12345, 999998, 32'h8000_0000, 32'h7FFF_FFFF, 0};
    rst = 1;
    cfg_we = 0;
    cfg_data = 0;
    mismatches = 0;
    cycles = 0;
    accepted = 0;
    cutoff_shadow = CUTOFF_RESET;
    foreach (run_count[i]) begin
      run_count[i] = 0;
      run_mean[i] = 0;
      run_var[i] = 0;
    end
    repeat (4) @(posedge clk);
    rst <= 0;
    foreach (directed[i]) sample_q.push_back(directed[i]);
    drain();
    queue_random(300);
    drain();
    write_cutoff(0);
    queue_random(150);
    drain();
    write_cutoff('1);
    queue_random(200);
    drain();
    write_cutoff(1);
    sample_q.push_back(0);
    sample_q.push_back(1);
    queue_random(100);
    drain();
    write_cutoff($urandom);
    queue_random(250);
    drain();
    if (mismatches == 0 && stats_q.size() == 0)
      $display("** running_mean_variance_with_cutoff_top: PASSED **");
    else
      $display("** running_mean_variance_with_cutoff_top: FAILED **");
    $finish;
  end

endmodule
